@@ src/qsu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsu_pkg: shared types for the quoted string unescaper
// scan modes, status codes and the command word passed from front to back
// ----------------------------------------------------------------------------
package qsu_pkg;

	localparam int QSU_QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_STR,
		MODE_ESC,
		MODE_HEX
	} mode_t;

	localparam logic [2:0] ST_BUSY    = 3'd0;
	localparam logic [2:0] ST_CLOSED  = 3'd1;
	localparam logic [2:0] ST_NOQUOTE = 3'd2;
	localparam logic [2:0] ST_UNTERM  = 3'd3;
	localparam logic [2:0] ST_NEWLINE = 3'd4;
	localparam logic [2:0] ST_BADHEX  = 3'd5;
	localparam logic [2:0] ST_SURR    = 3'd6;
	localparam logic [2:0] ST_BADESC  = 3'd7;

	typedef enum logic {
		CMD_SINGLE,
		CMD_UTF8
	} cmd_kind_t;

	// single: one result, data[7:0] is the byte when byte_valid
	// utf8: data is a code point to be encoded into 1..3 bytes
	typedef struct packed {
		cmd_kind_t   kind;
		logic        byte_valid;
		logic [15:0] data;
		logic [2:0]  status;
	} cmd_t;

	typedef struct packed {
		logic avail;
		cmd_t cmd;
	} q_head_t;

endpackage
`default_nettype wire

@@ src/qsu_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsu_front: string scanner
// tracks quote, escape and hex state and turns each byte into one command
// ----------------------------------------------------------------------------
module qsu_front import qsu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] in_byte,
	output logic            in_ready,
	input  wire logic       q_full,
	output logic            push,
	output cmd_t            push_cmd
);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	mode_t       mode_q, mode_d;
	logic [1:0]  hex_count_q, hex_count_d;
	logic [15:0] code_point_q, code_point_d;
	logic [4:0]  hex;
	logic [15:0] cp_new;
	logic        surrogate;

	// bit 4 flags a valid digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		unique case (c) inside
			[8'h30:8'h39]: r = {1'b1, c[3:0]};
			[8'h41:8'h46],
			[8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
			default:       r = 5'd0;
		endcase
		return r;
	endfunction

	assign in_ready  = !q_full;
	assign push      = in_valid && in_ready;
	assign hex       = hex_digit(in_byte);
	assign cp_new    = {code_point_q[11:0], hex[3:0]};
	assign surrogate = (cp_new[15:11] == 5'b11011);

	// next state
	always_comb begin
		mode_d       = mode_q;
		hex_count_d  = hex_count_q;
		code_point_d = code_point_q;
		unique case (mode_q)
			MODE_IDLE: begin
				if (in_byte == CH_QUOTE) mode_d = MODE_STR;
			end
			MODE_STR: begin
				if (in_byte == CH_NUL || in_byte == CH_LF || in_byte == CH_QUOTE) begin
					mode_d = MODE_IDLE;
				end else if (in_byte == CH_BSL) begin
					mode_d = MODE_ESC;
				end
			end
			MODE_ESC: begin
				hex_count_d  = '0;
				code_point_d = '0;
				unique case (in_byte)
					CH_QUOTE, CH_BSL, CH_N, CH_T, CH_R: mode_d = MODE_STR;
					CH_U:    mode_d = MODE_HEX;
					default: mode_d = MODE_IDLE;
				endcase
			end
			MODE_HEX: begin
				if (!hex[4]) begin
					mode_d       = MODE_IDLE;
					hex_count_d  = '0;
					code_point_d = '0;
				end else if (hex_count_q != 2'd3) begin
					hex_count_d  = hex_count_q + 2'd1;
					code_point_d = cp_new;
				end else begin
					hex_count_d  = '0;
					code_point_d = '0;
					mode_d       = surrogate ? MODE_IDLE : MODE_STR;
				end
			end
			default: mode_d = MODE_IDLE;
		endcase
	end

	// command for this byte
	always_comb begin
		push_cmd = '{kind: CMD_SINGLE, byte_valid: 1'b0, data: 16'd0, status: ST_BUSY};
		unique case (mode_q)
			MODE_IDLE: begin
				if (in_byte != CH_QUOTE) push_cmd.status = ST_NOQUOTE;
			end
			MODE_STR: begin
				if (in_byte == CH_NUL) begin
					push_cmd.status = ST_UNTERM;
				end else if (in_byte == CH_LF) begin
					push_cmd.status = ST_NEWLINE;
				end else if (in_byte == CH_QUOTE) begin
					push_cmd.status = ST_CLOSED;
				end else if (in_byte != CH_BSL) begin
					push_cmd.byte_valid = 1'b1;
					push_cmd.data       = {8'd0, in_byte};
				end
			end
			MODE_ESC: begin
				unique case (in_byte)
					CH_QUOTE, CH_BSL: begin
						push_cmd.byte_valid = 1'b1;
						push_cmd.data       = {8'd0, in_byte};
					end
					CH_N: begin
						push_cmd.byte_valid = 1'b1;
						push_cmd.data       = {8'd0, CH_LF};
					end
					CH_T: begin
						push_cmd.byte_valid = 1'b1;
						push_cmd.data       = {8'd0, CH_TAB};
					end
					CH_R: begin
						push_cmd.byte_valid = 1'b1;
						push_cmd.data       = {8'd0, CH_CR};
					end
					CH_U:    push_cmd.status = ST_BUSY;
					default: push_cmd.status = ST_BADESC;
				endcase
			end
			MODE_HEX: begin
				if (!hex[4]) begin
					push_cmd.status = ST_BADHEX;
				end else if (hex_count_q == 2'd3) begin
					if (surrogate) begin
						push_cmd.status = ST_SURR;
					end else begin
						push_cmd.kind       = CMD_UTF8;
						push_cmd.byte_valid = 1'b1;
						push_cmd.data       = cp_new;
					end
				end
			end
			default: push_cmd.status = ST_BUSY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			hex_count_q  <= '0;
			code_point_q <= '0;
		end else if (push) begin
			mode_q       <= mode_d;
			hex_count_q  <= hex_count_d;
			code_point_q <= code_point_d;
		end
	end

endmodule
`default_nettype wire

@@ src/qsu_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsu_queue: command queue
// small register queue between scanner and encoder
// ----------------------------------------------------------------------------
module qsu_queue import qsu_pkg::*; #(
	parameter int DEPTH = QSU_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output q_head_t   head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head.avail = (count_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.avail;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ src/qsu_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsu_back: result generator
// expands commands into result words, utf-8 encodes code points
// ----------------------------------------------------------------------------
module qsu_back import qsu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire q_head_t    head,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_data,   // out_byte
	output logic [3:0]      out_user,   // out_valid flag, status[2:0]
	output logic            out_last
);

	localparam logic [15:0] LIM_1B = 16'h0080;
	localparam logic [15:0] LIM_2B = 16'h0800;
	localparam logic [7:0]  LEAD2  = 8'hC0;
	localparam logic [7:0]  LEAD3  = 8'hE0;
	localparam logic [7:0]  CONT   = 8'h80;

	logic [1:0]  idx_q;
	logic [1:0]  nbytes;
	logic [15:0] cp;
	logic [7:0]  res_byte;
	logic        res_final;
	logic        load;

	assign cp     = head.cmd.data;
	assign nbytes = (cp < LIM_1B) ? 2'd1 : (cp < LIM_2B) ? 2'd2 : 2'd3;

	always_comb begin
		res_byte  = head.cmd.data[7:0];
		res_final = 1'b1;
		if (head.cmd.kind == CMD_UTF8) begin
			res_final = (idx_q == nbytes - 2'd1);
			case (nbytes)
				2'd1: res_byte = cp[7:0];
				2'd2: res_byte = (idx_q == 2'd0) ? (LEAD2 | {3'd0, cp[10:6]})
					: (CONT | {2'd0, cp[5:0]});
				default: begin
					case (idx_q)
						2'd0:    res_byte = LEAD3 | {4'd0, cp[15:12]};
						2'd1:    res_byte = CONT | {2'd0, cp[11:6]};
						default: res_byte = CONT | {2'd0, cp[5:0]};
					endcase
				end
			endcase
		end
	end

	assign load = !out_valid || out_ready;
	assign pop  = load && head.avail && res_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q     <= '0;
		end else if (load) begin
			out_valid <= head.avail;
			if (head.avail) idx_q <= res_final ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && head.avail) begin
			out_data <= head.cmd.byte_valid ? res_byte : 8'd0;
			out_user <= {head.cmd.status, head.cmd.byte_valid};
			out_last <= res_final;
		end
	end

endmodule
`default_nettype wire

@@ src/quoted_string_unescape_utf8.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quoted_string_unescape_utf8: quoted string unescaper with utf-8 output
// scanner front, command queue and encoder back on word streams
// ----------------------------------------------------------------------------
// Feed a double-quoted token one byte per word, starting with the opening
// quote; a zero byte marks end of input. Every input word gives one result
// word, except a \u escape whose fourth hex digit gives one to three utf-8
// bytes with tlast only on the final one. Results carry the decoded byte in
// tdata and {status, byte flag} in tuser; status 1 is a closed string,
// status 2..7 are errors, after which the scanner waits for a new quote.
// The front takes one byte every cycle while the queue has room; the back
// sends one result word every cycle while the master is ready, so input is
// accepted back to back and only stalls when a multi-byte \u escape or a
// stalled master fills the queue; each result is registered in the back.
// ----------------------------------------------------------------------------
module quoted_string_unescape_utf8 import qsu_pkg::*; #(
	parameter int QUEUE_DEPTH = QSU_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // in_byte[7:0]
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // out_byte[7:0]
	output logic [3:0]      m_axis_tuser,   // out_valid[0], status[3:1]
	output logic            m_axis_tlast
);

	// scanner to queue
	logic    push;
	cmd_t    push_cmd;
	logic    q_full;
	// queue to encoder
	q_head_t head;
	logic    pop;

	qsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_byte  (s_axis_tdata),
		.in_ready (s_axis_tready),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// decouples the scanner from utf-8 expansion and output stalls
	qsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head)
	);

	// output register lives in the back, so it offers one word a cycle while the master is ready
	qsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule
`default_nettype wire

@@ src/qsu_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsu_checker: output stream checks
// properties of the result words seen at the master port
// ----------------------------------------------------------------------------
module qsu_checker import qsu_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic [3:0] m_axis_tuser,
	input wire logic       m_axis_tlast
);

	// a stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	// a word with a byte is always busy status
	a_byte_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[3:1] == ST_BUSY)
		else $error("byte word with non-busy status");

	// a word without a byte ends its input byte and carries zero data
	a_nobyte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 8'd0)
		else $error("status word not last or data not zero");

	// a non-last word is followed at once by a continuation byte of the same sequence
	a_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast
		|=> m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[7:6] == 2'b10)
		else $error("utf-8 sequence broken");

endmodule

bind quoted_string_unescape_utf8 qsu_checker u_qsu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
